@@ rtl/core/chd_pkg.sv @@
// chd_pkg: shared types, character codes and status codes for the chunked
// body decoder. No dependencies.
`default_nettype none

package chd_pkg;

    // default width of the chunk size accumulator
    localparam int SIZE_BITS_DEF = 32;

    localparam logic [7:0] CHR_SEMI = 8'h3B;
    localparam logic [7:0] CHR_CR   = 8'h0D;
    localparam logic [7:0] CHR_LF   = 8'h0A;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       consumed;
        logic [1:0] status;
        logic       chunk_end;
        logic       buffer_end;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // ASCII hex digit decode, both cases
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.val = 4'(c[2:0] + 3'd1) + 4'd8;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/http_chunked_body_decoder.sv @@
// http_chunked_body_decoder: top level of the chunked body decoder.
// Instantiates chd_in_stage, chd_parse_core and chd_out_stage; uses chd_pkg.
//
// Usage:
//   Slave side takes one raw body byte per beat in s_axis_tdata; s_axis_tlast
//   marks the last byte of the sender's buffer and is only echoed.
//   Master side gives exactly one result beat per input beat: the data byte
//   in m_axis_tdata, flags in m_axis_tuser, the echoed marker in m_axis_tlast.
//   Path: an accepted beat is registered at the input stage, then decoded
//   and loaded into the result register once that register is free, and
//   its result then shows on m_axis_tvalid.
//   Throughput: one byte per clock while m_axis_tready is high; the decoder state update
//   (hex digit shift-in, chunk count decrement) is plain combinational logic.
//   Stall: when m_axis_tready is low with a result pending, the result and
//   input registers hold and s_axis_tready drops once the input register is
//   full; no beat is lost or repeated.
//   Reset (i_rst_n low, synchronous): both pipeline registers empty, parser
//   back at the start of a size line. After a zero-size chunk (done) or a
//   framing error the block keeps accepting beats but marks them
//   not consumed and holds the status until reset.
`default_nettype none

module http_chunked_body_decoder #(
    parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // last_in_buffer
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] payload_byte
    output logic [4:0]      m_axis_tuser,   // [0] payload_valid, [1] consumed,
                                            // [3:2] status, [4] chunk_end
    output logic            m_axis_tlast    // buffer_end
);
    import chd_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_free;
    logic       fire;
    t_result    core_res;
    t_result    out_res;

    // a beat leaves the input register whenever the result register can take it
    assign fire = in_valid && out_free;

    chd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_take  (out_free),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .o_last  (in_last)
    );

    chd_parse_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (in_byte),
        .i_last  (in_last),
        .o_res   (core_res)
    );

    chd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_valid),
        .i_res   (core_res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = out_res.payload_byte;
    assign m_axis_tuser = {out_res.chunk_end, out_res.status,
                           out_res.consumed, out_res.payload_valid};
    assign m_axis_tlast = out_res.buffer_end;

endmodule

`default_nettype wire

@@ rtl/core/chd_in_stage.sv @@
// chd_in_stage: input register for the byte stream.
// Depends on nothing but the handshake from the next stage.
`default_nettype none

module chd_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire logic       i_take,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_last
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

`default_nettype wire

@@ rtl/core/chd_parse_core.sv @@
// chd_parse_core: size line parser, data countdown and CRLF check.
// Holds the decoder state; uses chd_pkg.
`default_nettype none

module chd_parse_core #(
    parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output chd_pkg::t_result o_res
);
    import chd_pkg::*;

    localparam logic [2:0] PH_SIZE = 3'd0;
    localparam logic [2:0] PH_DATA = 3'd1;
    localparam logic [2:0] PH_CR   = 3'd2;
    localparam logic [2:0] PH_LF   = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;
    localparam logic [2:0] PH_ERR  = 3'd5;

    logic [2:0]           r_phase,  n_phase;
    logic [SIZE_BITS-1:0] r_remain, n_remain;
    logic [SIZE_BITS-1:0] r_accum,  n_accum;
    logic                 r_digit,  n_digit;
    logic                 r_ignore, n_ignore;
    logic                 r_bad,    n_bad;
    logic                 r_prev_cr, n_prev_cr;

    t_hex                 hex;
    logic [SIZE_BITS-1:0] remain_dec;
    t_result              res;

    assign hex        = hex_decode(i_byte);
    assign remain_dec = (r_remain != '0) ? r_remain - SIZE_BITS'(1) : '0;

    always_comb begin
        n_phase   = r_phase;
        n_remain  = r_remain;
        n_accum   = r_accum;
        n_digit   = r_digit;
        n_ignore  = r_ignore;
        n_bad     = r_bad;
        n_prev_cr = r_prev_cr;
        res       = '0;
        res.consumed   = 1'b1;
        res.buffer_end = i_last;
        case (r_phase)
            PH_SIZE: begin
                if (r_prev_cr && i_byte == CHR_LF) begin
                    if (r_bad || !r_digit) begin
                        n_phase = PH_ERR;
                    end else if (r_accum == '0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_remain = r_accum;
                        n_phase  = PH_DATA;
                    end
                    n_accum   = '0;
                    n_digit   = 1'b0;
                    n_ignore  = 1'b0;
                    n_bad     = 1'b0;
                    n_prev_cr = 1'b0;
                end else begin
                    if (!r_ignore) begin
                        if (i_byte == CHR_SEMI || i_byte == CHR_CR || i_byte == CHR_LF) begin
                            n_ignore = 1'b1;
                        end else if (!hex.ok) begin
                            n_bad = 1'b1;
                        end else if (!r_bad) begin
                            // top nibble set: next digit would overflow
                            if (r_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                                n_bad = 1'b1;
                            end else begin
                                n_accum = {r_accum[SIZE_BITS-5:0], hex.val};
                                n_digit = 1'b1;
                            end
                        end
                    end
                    n_prev_cr = (i_byte == CHR_CR);
                end
            end
            PH_DATA: begin
                res.payload_valid = 1'b1;
                res.payload_byte  = i_byte;
                n_remain          = remain_dec;
                if (remain_dec == '0) begin
                    res.chunk_end = 1'b1;
                    n_phase       = PH_CR;
                end
            end
            PH_CR: begin
                if (i_byte == CHR_CR) begin
                    n_phase = PH_LF;
                end else begin
                    n_phase      = PH_ERR;
                    res.consumed = 1'b0;
                end
            end
            PH_LF: begin
                if (i_byte == CHR_LF) begin
                    n_phase   = PH_SIZE;
                    n_accum   = '0;
                    n_digit   = 1'b0;
                    n_ignore  = 1'b0;
                    n_bad     = 1'b0;
                    n_prev_cr = 1'b0;
                end else begin
                    n_phase      = PH_ERR;
                    res.consumed = 1'b0;
                end
            end
            default: begin
                res.consumed = 1'b0;
            end
        endcase
        res.status = (n_phase == PH_DONE) ? ST_DONE :
                     (n_phase == PH_ERR)  ? ST_ERR  : ST_RUN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SIZE;
            r_remain  <= '0;
            r_accum   <= '0;
            r_digit   <= 1'b0;
            r_ignore  <= 1'b0;
            r_bad     <= 1'b0;
            r_prev_cr <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_remain  <= n_remain;
            r_accum   <= n_accum;
            r_digit   <= n_digit;
            r_ignore  <= n_ignore;
            r_bad     <= n_bad;
            r_prev_cr <= n_prev_cr;
        end
    end

    assign o_res = res;

endmodule

`default_nettype wire

@@ rtl/core/chd_out_stage.sv @@
// chd_out_stage: result register in front of the master-side stream.
// Uses chd_pkg for the result struct.
`default_nettype none

module chd_out_stage (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire chd_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  wire logic        i_ready,
    output chd_pkg::t_result o_res
);
    import chd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

@@ rtl/core/chd_checker.sv @@
// chd_checker: port-level assertions for the chunked body decoder, bound
// to http_chunked_body_decoder. Uses chd_pkg status codes.
`default_nettype none

module chd_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       m_axis_tvalid,
    input  wire logic       m_axis_tready,
    input  wire logic [7:0] m_axis_tdata,
    input  wire logic [4:0] m_axis_tuser,
    input  wire logic       m_axis_tlast
);
    import chd_pkg::*;

    logic       out_beat;
    logic       r_term_seen;
    logic [1:0] r_term_status;

    assign out_beat = m_axis_tvalid && m_axis_tready;

    // remember the first terminal status seen on the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_seen   <= 1'b0;
            r_term_status <= ST_RUN;
        end else if (out_beat && !r_term_seen && m_axis_tuser[3:2] != ST_RUN) begin
            r_term_seen   <= 1'b1;
            r_term_status <= m_axis_tuser[3:2];
        end
    end

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_payload_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tuser[1] && m_axis_tuser[3:2] == ST_RUN)
        else $error("payload byte outside normal decoding");

    a_cend_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[4] |-> m_axis_tuser[0])
        else $error("chunk end without payload byte");

    a_term_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_term_seen |->
            m_axis_tuser[3:2] == r_term_status && !m_axis_tuser[1] && !m_axis_tuser[0])
        else $error("terminal status not held");

endmodule

bind http_chunked_body_decoder chd_checker u_chd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// tb: self-checking bench for http_chunked_body_decoder, one stream beat per body byte.
// Builds a chunked body, drives it with random gaps and result stalls, and checks
// every result beat against an in-bench decoder model. Uses chd_pkg and the DUT only.

module tb;
    import chd_pkg::*;

    localparam int SIZE_BITS = SIZE_BITS_DEF;

    // decoder phases of the in-bench model
    typedef enum logic [2:0] {
        PH_SIZE, PH_DATA, PH_CR, PH_LF, PH_DONE, PH_ERR
    } t_phase;

    // one pending body byte; hold_for_drain makes the sender wait until all
    // outstanding results are back before offering it
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold_for_drain;
    } t_body_beat;

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast  = 1'b0;    // last_in_buffer
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] payload_byte
    logic [4:0] m_axis_tuser;            // [0] payload_valid, [1] consumed,
                                         // [3:2] status, [4] chunk_end
    logic       m_axis_tlast;            // buffer_end

    http_chunked_body_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    t_body_beat body_q[$];       // bytes still to send
    t_result    result_q[$];     // predicted result beats, oldest first
    bit         drain_pending = 1'b0;
    logic       byte_took = 1'b0;   // beat accepted at the last rising edge
    int         n_taken = 0;
    int         n_total = 0;
    int         n_errors = 0;
    int         cyc = 0;
    logic       calm;

    // a stretch with no gaps and no stalls on either side
    assign calm = (cyc >= 500 && cyc < 900);

    // ------------------------------------------------------------------
    // Decoder model: parser state
    // ------------------------------------------------------------------
    t_phase               ph         = PH_SIZE;
    logic [SIZE_BITS-1:0] chunk_left = '0;
    logic [SIZE_BITS-1:0] size_acc   = '0;
    bit                   digit_seen = 1'b0;
    bit                   rest_skip  = 1'b0;
    bit                   bad_size   = 1'b0;
    bit                   last_cr    = 1'b0;

    function automatic int hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return 10 + int'(c - "a");
        if (c >= "A" && c <= "F") return 10 + int'(c - "A");
        return -1;
    endfunction

    function automatic void restart_line();
        size_acc   = '0;
        digit_seen = 1'b0;
        rest_skip  = 1'b0;
        bad_size   = 1'b0;
        last_cr    = 1'b0;
    endfunction

    // advances the model by one body byte and returns the result beat it gives
    function automatic t_result decode_byte(input logic [7:0] c, input logic lst);
        t_result r;
        int      d;
        r            = '0;
        r.consumed   = 1'b1;
        r.buffer_end = lst;
        case (ph)
            PH_SIZE: begin
                if (last_cr && c == CHR_LF) begin
                    // CR LF closes the size line
                    if (bad_size || !digit_seen) begin
                        ph = PH_ERR;
                    end else if (size_acc == 0) begin
                        ph = PH_DONE;
                    end else begin
                        chunk_left = size_acc;
                        ph         = PH_DATA;
                    end
                    restart_line();
                end else begin
                    if (!rest_skip) begin
                        d = hex_val(c);
                        if (c == CHR_SEMI || c == CHR_CR || c == CHR_LF) begin
                            rest_skip = 1'b1;
                        end else if (d < 0) begin
                            bad_size = 1'b1;
                        end else if (!bad_size) begin
                            // refuse a digit that would shift a set bit out
                            if (size_acc[SIZE_BITS-1 -: 4] != 0) begin
                                bad_size = 1'b1;
                            end else begin
                                size_acc   = {size_acc[SIZE_BITS-5:0], 4'(d)};
                                digit_seen = 1'b1;
                            end
                        end
                    end
                    last_cr = (c == CHR_CR);
                end
            end
            PH_DATA: begin
                r.payload_valid = 1'b1;
                r.payload_byte  = c;
                if (chunk_left != 0) chunk_left = chunk_left - SIZE_BITS'(1);
                if (chunk_left == 0) begin
                    r.chunk_end = 1'b1;
                    ph          = PH_CR;
                end
            end
            PH_CR: begin
                if (c == CHR_CR) begin
                    ph = PH_LF;
                end else begin
                    ph         = PH_ERR;
                    r.consumed = 1'b0;
                end
            end
            PH_LF: begin
                if (c == CHR_LF) begin
                    ph = PH_SIZE;
                    restart_line();
                end else begin
                    ph         = PH_ERR;
                    r.consumed = 1'b0;
                end
            end
            default: begin
                r.consumed = 1'b0;
            end
        endcase
        r.status = (ph == PH_DONE) ? ST_DONE : (ph == PH_ERR) ? ST_ERR : ST_RUN;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Body builders
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        t_body_beat beat;
        beat.data           = b;
        beat.last           = ($urandom_range(0, 7) == 0);
        beat.hold_for_drain = drain_pending;
        drain_pending       = 1'b0;
        body_q.insert(body_q.size(), beat);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input int d, input bit upper);
        if (d < 10) return 8'("0" + d);
        return upper ? 8'("A" + d - 10) : 8'("a" + d - 10);
    endfunction

    // line extension: ';', a lone LF or a lone CR, then junk without CR
    task automatic push_line_noise();
        logic [7:0] b;
        case ($urandom_range(0, 2))
            0: push_byte(CHR_SEMI);
            1: push_byte(CHR_LF);
            default: begin
                push_byte(CHR_CR);
                do b = 8'($urandom); while (b == CHR_CR || b == CHR_LF);
                push_byte(b);
            end
        endcase
        repeat ($urandom_range(0, 6)) begin
            do b = 8'($urandom); while (b == CHR_CR);
            push_byte(b);
        end
    endtask

    // hex size with random digit case and a few leading zeros, then CR LF
    task automatic push_size_line(input int unsigned size, input bit with_ext);
        int top;
        top = 0;
        for (int i = 0; i < 8; i++) if (((size >> (4 * i)) & 15) != 0) top = i;
        repeat ($urandom_range(0, 2)) push_byte("0");
        for (int i = top; i >= 0; i--)
            push_byte(hex_char((size >> (4 * i)) & 15, 1'($urandom_range(0, 1))));
        if (with_ext) push_line_noise();
        push_byte(CHR_CR);
        push_byte(CHR_LF);
    endtask

    task automatic push_chunk(input int unsigned size, input bit with_ext);
        push_size_line(size, with_ext);
        repeat (size) push_byte(8'($urandom));
        push_byte(CHR_CR);
        push_byte(CHR_LF);
    endtask

    // the run can end only once, so one closing case is picked per seed
    task automatic push_ending();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0: push_size_line(0, 1'($urandom_range(0, 1)));   // last chunk: done
            1: begin                                      // non-hex digit
                push_byte(hex_char($urandom_range(0, 15), 1'b0));
                do b = 8'($urandom);
                while (hex_val(b) >= 0 || b == CHR_SEMI || b == CHR_CR || b == CHR_LF);
                push_byte(b);
                push_byte(hex_char($urandom_range(0, 15), 1'b1));
                push_text("\r\n");
            end
            2: begin                                      // size too wide
                push_byte(hex_char($urandom_range(1, 15), 1'($urandom_range(0, 1))));
                repeat (SIZE_BITS / 4)
                    push_byte(hex_char($urandom_range(0, 15),
                                       1'($urandom_range(0, 1))));
                push_text("\r\n");
            end
            3: begin                                      // empty size
                if ($urandom_range(0, 1)) push_line_noise();
                push_text("\r\n");
            end
            4: begin                                      // CR missing after data
                push_text("2\r\n");
                repeat (2) push_byte(8'($urandom));
                do b = 8'($urandom); while (b == CHR_CR);
                push_byte(b);
            end
            default: begin                                // LF missing after CR
                push_text("2\r\n");
                repeat (2) push_byte(8'($urandom));
                push_byte(CHR_CR);
                do b = 8'($urandom); while (b == CHR_LF);
                push_byte(b);
            end
        endcase
        // once done or in error, bytes must come back not consumed
        repeat (12) push_byte(8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Sender: offers the next byte at the falling edge, holds it until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : sender
        t_body_beat beat;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || byte_took) begin
            if (body_q.size() != 0
                && !(body_q[0].hold_for_drain && result_q.size() != 0)
                && (calm || $urandom_range(0, 99) >= 29)) begin
                beat = body_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= beat.data;
                s_axis_tlast  <= beat.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random backpressure on the result side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 29);
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted byte, checks every result beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result want;
        cyc       <= cyc + 1;
        byte_took <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            result_q.insert(result_q.size(), decode_byte(s_axis_tdata, s_axis_tlast));
            n_taken++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                $error("result beat with no byte outstanding");
                n_errors++;
            end else begin
                want = result_q.pop_front();
                check_field("payload_valid", 8'(want.payload_valid), 8'(m_axis_tuser[0]));
                check_field("payload_byte", want.payload_byte, m_axis_tdata);
                check_field("consumed", 8'(want.consumed), 8'(m_axis_tuser[1]));
                check_field("status", 8'(want.status), 8'(m_axis_tuser[3:2]));
                check_field("chunk_end", 8'(want.chunk_end), 8'(m_axis_tuser[4]));
                check_field("buffer_end", 8'(want.buffer_end), 8'(m_axis_tlast));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        // directed: one-byte chunk with a zero byte, lone LF and lone CR in
        // the size line, leading zeros with an empty extension
        push_text("1\r\n");
        push_byte(8'h00);
        push_text("\r\n");
        push_text("2\n\rz\r\n");
        push_byte(8'hFF);
        push_byte(8'h80);
        push_text("\r\n");
        drain_pending = 1'b1;
        push_text("0001;\r\n");
        push_byte(8'h7F);
        push_text("\r\n");

        // random well-formed chunks, mostly short, with line noise now and then
        while (body_q.size() < 1030) begin
            if ($urandom_range(0, 39) == 0) drain_pending = 1'b1;
            push_chunk(($urandom_range(0, 7) == 0) ? $urandom_range(9, 48)
                                                   : $urandom_range(1, 8),
                       $urandom_range(0, 3) == 0);
        end
        push_ending();
        n_total = body_q.size();

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_total || result_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("http_chunked_body_decoder test passed");
        end else begin
            $display("http_chunked_body_decoder test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("http_chunked_body_decoder test failed");
        $finish;
    end

endmodule
